>>> hw/rtl/cgt_pkg.sv
// cgt_pkg: shared types, codes and reset values for the awareness message
// generation trigger. Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package cgt_pkg;

    localparam int CAUSE_W = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FIRST    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_HEADING  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_DISTANCE = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_SPEED    = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_ELAPSED  = 3'd5;
    localparam logic [CAUSE_W-1:0] CAUSE_ROADSIDE = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_VEHICLE_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROADSIDE_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MAX    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_THR     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_THR    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_THR       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LIMIT    = 3'd7;

    localparam logic [15:0] RST_ROADSIDE_PERIOD = 16'd1000;
    localparam logic [15:0] RST_INTERVAL_MIN    = 16'd100;
    localparam logic [15:0] RST_INTERVAL_MAX    = 16'd1000;
    localparam logic [10:0] RST_HEADING_THR     = 11'd40;
    localparam logic [15:0] RST_DISTANCE_THR    = 16'd400;
    localparam logic [13:0] RST_SPEED_THR       = 14'd50;
    localparam logic [2:0]  RST_REPEAT_LIMIT    = 3'd3;

    localparam logic [31:0] CONTAINER_GAP_MS = 32'd500;
    localparam logic signed [13:0] HALF_TURN = 14'sd1800;
    localparam logic signed [13:0] FULL_TURN = 14'sd3600;

    typedef struct packed {
        logic        vehicle_mode;
        logic [15:0] roadside_period_ms;
        logic [15:0] interval_min_ms;
        logic [15:0] interval_max_ms;
        logic [10:0] heading_threshold;
        logic [15:0] distance_threshold;
        logic [13:0] speed_threshold;
        logic [2:0]  repeat_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] heading;
        logic [31:0] travelled_cm;
        logic [13:0] speed;
        logic        tx_ok;
        logic        low_freq_avail;
        logic        special_avail;
    } item_t;

    typedef struct packed {
        logic        generate_res;
        logic [CAUSE_W-1:0] cause;
        logic        with_low_freq;
        logic        with_special;
        logic [15:0] current_interval_ms;
    } result_t;

    typedef struct packed {
        logic        started;
        logic [31:0] last_gen_time;
        logic [11:0] prev_heading;
        logic [31:0] prev_distance;
        logic [13:0] prev_speed;
        logic [15:0] gen_interval;
        logic [2:0]  repeat_count;
        logic        dynamic_active;
        logic [31:0] last_low_freq_time;
        logic        low_freq_sent;
        logic [31:0] last_special_time;
        logic        special_sent;
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/cam_generation_trigger_core.sv
// cam_generation_trigger_core: top level of the awareness message generation
// trigger: input register, decision logic, state and result register.
// Depends on cgt_pkg, cgt_cfg_regs and cgt_decide.
//
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid / in_stall   now_ms, heading, travelled_cm, speed,
//                                            tx_ok, low_freq_avail, special_avail
//  out      source     out_valid / out_stall generate_res, cause, with_low_freq,
//                                            with_special, current_interval_ms
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One tick per cycle while out_stall is low; input then result register.
//  Ticks are decided in the cycle they leave the input register, against state
//  written by the previous tick, so consecutive ticks never wait on each other.
//  An output stall holds the result register and, through it, the input register.
//  Reset clears state except gen_interval, loads cfg defaults; no clearing pass.
`default_nettype none

module cam_generation_trigger_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [31:0]                     now_ms,
    input  wire logic [11:0]                     heading,
    input  wire logic [31:0]                     travelled_cm,
    input  wire logic [13:0]                     speed,
    input  wire logic                            tx_ok,
    input  wire logic                            low_freq_avail,
    input  wire logic                            special_avail,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 generate_res,
    output logic [cgt_pkg::CAUSE_W-1:0]          cause,
    output logic                                 with_low_freq,
    output logic                                 with_special,
    output logic [15:0]                          current_interval_ms,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cgt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cgt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cgt_pkg::cfg_t    cfg;
    cgt_pkg::item_t   item_reg;
    logic             item_valid_reg;
    cgt_pkg::state_t  st_reg;
    cgt_pkg::state_t  st_next;
    cgt_pkg::result_t res_next;
    cgt_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             out_adv;
    logic             item_adv;
    logic             in_xfer;

    cgt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cgt_decide u_decide (
        .cfg     (cfg),
        .item    (item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign out_adv  = !res_valid_reg || !out_stall;
    assign item_adv = item_valid_reg && out_adv;
    assign in_stall = item_valid_reg && !out_adv;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg         <= '{gen_interval: cgt_pkg::RST_INTERVAL_MAX, default: '0};
        end
        else
        begin
            if (in_xfer)
                item_valid_reg <= 1'b1;
            else if (item_adv)
                item_valid_reg <= 1'b0;

            if (out_adv)
                res_valid_reg <= item_valid_reg;

            if (item_adv)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.now_ms         <= now_ms;
            item_reg.heading        <= heading;
            item_reg.travelled_cm   <= travelled_cm;
            item_reg.speed          <= speed;
            item_reg.tx_ok          <= tx_ok;
            item_reg.low_freq_avail <= low_freq_avail;
            item_reg.special_avail  <= special_avail;
        end
        if (item_adv)
            res_reg <= res_next;
    end

    assign out_valid           = res_valid_reg;
    assign generate_res        = res_reg.generate_res;
    assign cause               = res_reg.cause;
    assign with_low_freq       = res_reg.with_low_freq;
    assign with_special        = res_reg.with_special;
    assign current_interval_ms = res_reg.current_interval_ms;

endmodule

`default_nettype wire

>>> hw/rtl/cgt_cfg_regs.sv
// cgt_cfg_regs: configuration register file written over the cfg channel.
// Depends on cgt_pkg.
`default_nettype none

module cgt_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cgt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cgt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output cgt_pkg::cfg_t                       cfg
);

    cgt_pkg::cfg_t cfg_reg;
    cgt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cgt_pkg::REG_VEHICLE_MODE:    cfg_next.vehicle_mode       = cfg_data[0];
                cgt_pkg::REG_ROADSIDE_PERIOD: cfg_next.roadside_period_ms = cfg_data;
                cgt_pkg::REG_INTERVAL_MIN:    cfg_next.interval_min_ms    = cfg_data;
                cgt_pkg::REG_INTERVAL_MAX:    cfg_next.interval_max_ms    = cfg_data;
                cgt_pkg::REG_HEADING_THR:     cfg_next.heading_threshold  = cfg_data[10:0];
                cgt_pkg::REG_DISTANCE_THR:    cfg_next.distance_threshold = cfg_data;
                cgt_pkg::REG_SPEED_THR:       cfg_next.speed_threshold    = cfg_data[13:0];
                cgt_pkg::REG_REPEAT_LIMIT:    cfg_next.repeat_limit       = cfg_data[2:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vehicle_mode       <= 1'b1;
            cfg_reg.roadside_period_ms <= cgt_pkg::RST_ROADSIDE_PERIOD;
            cfg_reg.interval_min_ms    <= cgt_pkg::RST_INTERVAL_MIN;
            cfg_reg.interval_max_ms    <= cgt_pkg::RST_INTERVAL_MAX;
            cfg_reg.heading_threshold  <= cgt_pkg::RST_HEADING_THR;
            cfg_reg.distance_threshold <= cgt_pkg::RST_DISTANCE_THR;
            cfg_reg.speed_threshold    <= cgt_pkg::RST_SPEED_THR;
            cfg_reg.repeat_limit       <= cgt_pkg::RST_REPEAT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cgt_decide.sv
// cgt_decide: combinational trigger decision and next state for one tick.
// Depends on cgt_pkg.
`default_nettype none

module cgt_decide (
    input  wire cgt_pkg::cfg_t   cfg,
    input  wire cgt_pkg::item_t  item,
    input  wire cgt_pkg::state_t st,
    output cgt_pkg::state_t      st_next,
    output cgt_pkg::result_t     res
);

    localparam int CAUSE_W_L = cgt_pkg::CAUSE_W;

    logic [31:0] elapsed;
    logic signed [13:0] hd;
    logic signed [13:0] hd_wrap;
    logic [12:0] hmag;
    logic [31:0] dd;
    logic [31:0] dmag;
    logic [13:0] sdiff;
    logic [CAUSE_W_L-1:0] cause;
    logic [31:0] clamp_lo;
    logic [15:0] clamp_val;
    logic [2:0]  rc_inc;
    logic        gen;
    logic        lf_ok;
    logic        sp_ok;

    always_comb
    begin
        elapsed = item.now_ms - st.last_gen_time;

        hd = $signed({2'b00, item.heading}) - $signed({2'b00, st.prev_heading});
        if (hd > cgt_pkg::HALF_TURN)
            hd_wrap = hd - cgt_pkg::FULL_TURN;
        else if (hd < -cgt_pkg::HALF_TURN)
            hd_wrap = hd + cgt_pkg::FULL_TURN;
        else
            hd_wrap = hd;
        hmag = hd_wrap[13] ? 13'(-hd_wrap) : hd_wrap[12:0];

        dd = item.travelled_cm - st.prev_distance;
        dmag = dd[31] ? (32'd0 - dd) : dd;

        sdiff = (item.speed >= st.prev_speed) ? (item.speed - st.prev_speed)
                                               : (st.prev_speed - item.speed);

        priority if (!st.started)
            cause = cgt_pkg::CAUSE_FIRST;
        else if (!cfg.vehicle_mode)
            cause = (elapsed >= {16'd0, cfg.roadside_period_ms}) ? cgt_pkg::CAUSE_ROADSIDE
                                                               : cgt_pkg::CAUSE_NONE;
        else if (hmag > {2'b00, cfg.heading_threshold})
            cause = cgt_pkg::CAUSE_HEADING;
        else if (dmag > {16'd0, cfg.distance_threshold})
            cause = cgt_pkg::CAUSE_DISTANCE;
        else if (sdiff > cfg.speed_threshold)
            cause = cgt_pkg::CAUSE_SPEED;
        else if (elapsed >= {16'd0, st.gen_interval})
            cause = cgt_pkg::CAUSE_ELAPSED;
        else
            cause = cgt_pkg::CAUSE_NONE;

        gen = (cause != cgt_pkg::CAUSE_NONE) && item.tx_ok;

        // min clamp first, max wins on overlap
        clamp_lo = (elapsed < {16'd0, cfg.interval_min_ms}) ? {16'd0, cfg.interval_min_ms}
                                                            : elapsed;
        clamp_val = (clamp_lo > {16'd0, cfg.interval_max_ms}) ? cfg.interval_max_ms
                                                              : clamp_lo[15:0];
        rc_inc = st.repeat_count + 3'd1;

        lf_ok = item.low_freq_avail && (!st.low_freq_sent ||
                (item.now_ms - st.last_low_freq_time) >= cgt_pkg::CONTAINER_GAP_MS);
        sp_ok = item.special_avail && (!st.special_sent ||
                (item.now_ms - st.last_special_time) >= cgt_pkg::CONTAINER_GAP_MS);

        st_next = st;
        if (gen)
        begin
            if (cause == cgt_pkg::CAUSE_HEADING || cause == cgt_pkg::CAUSE_DISTANCE ||
                cause == cgt_pkg::CAUSE_SPEED)
            begin
                st_next.repeat_count   = 3'd1;
                st_next.dynamic_active = 1'b1;
                st_next.gen_interval   = clamp_val;
            end
            else if (cause == cgt_pkg::CAUSE_ELAPSED && st.dynamic_active)
            begin
                if (rc_inc >= cfg.repeat_limit)
                begin
                    st_next.repeat_count   = 3'd0;
                    st_next.dynamic_active = 1'b0;
                    st_next.gen_interval   = cfg.interval_max_ms;
                end
                else
                begin
                    st_next.repeat_count = rc_inc;
                end
            end
            if (lf_ok)
            begin
                st_next.last_low_freq_time = item.now_ms;
                st_next.low_freq_sent      = 1'b1;
            end
            if (sp_ok)
            begin
                st_next.last_special_time = item.now_ms;
                st_next.special_sent      = 1'b1;
            end
            st_next.started       = 1'b1;
            st_next.last_gen_time = item.now_ms;
            st_next.prev_heading  = item.heading;
            st_next.prev_distance = item.travelled_cm;
            st_next.prev_speed    = item.speed;
        end

        res.generate_res        = gen;
        res.cause               = gen ? cause : cgt_pkg::CAUSE_NONE;
        res.with_low_freq       = gen && lf_ok;
        res.with_special        = gen && sp_ok;
        res.current_interval_ms = cfg.vehicle_mode ? st_next.gen_interval
                                                   : cfg.roadside_period_ms;
    end

endmodule

`default_nettype wire

>>> dv/cam_generation_trigger_checker.sv
// cam_generation_trigger_checker: watches the tick, result and register channels of
// cam_generation_trigger_core, predicts each decision and compares it field by field.
// Depends on cgt_pkg for the payload structs, cause codes and register indexes.
`timescale 1ns / 100ps

module cam_generation_trigger_checker
    import cgt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [31:0]            now_ms,
    input  wire logic [11:0]            heading,
    input  wire logic [31:0]            travelled_cm,
    input  wire logic [13:0]            speed,
    input  wire logic                   tx_ok,
    input  wire logic                   low_freq_avail,
    input  wire logic                   special_avail,

    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic                   generate_res,
    input  wire logic [CAUSE_W-1:0]     cause,
    input  wire logic                   with_low_freq,
    input  wire logic                   with_special,
    input  wire logic [15:0]            current_interval_ms,

    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    output int                          mismatches,
    output int                          outstanding,
    output int                          compared
);

    cfg_t    settings;
    state_t  track;
    result_t expected_decisions[$];
    int      mismatch_cnt = 0;
    int      compare_cnt = 0;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t  result %0d %s: expected %0d, got %0d",
                 $time, compare_cnt, what, want, got);
        mismatch_cnt++;
    endtask

    function automatic result_t decide_tick(input item_t t);
        result_t            r;
        logic [31:0]        elapsed;
        logic [31:0]        dist_delta;
        logic [31:0]        dist_mag;
        logic [31:0]        clamped;
        logic [13:0]        speed_mag;
        logic [CAUSE_W-1:0] why;
        int                 head_delta;
        r = '0;
        why = CAUSE_NONE;
        elapsed = t.now_ms - track.last_gen_time;
        if (!track.started)
            why = CAUSE_FIRST;
        else if (!settings.vehicle_mode)
        begin
            if (elapsed >= {16'd0, settings.roadside_period_ms})
                why = CAUSE_ROADSIDE;
        end
        else
        begin
            head_delta = int'(t.heading) - int'(track.prev_heading);
            if (head_delta > HALF_TURN)
                head_delta -= FULL_TURN;
            else if (head_delta < -HALF_TURN)
                head_delta += FULL_TURN;
            if (head_delta < 0)
                head_delta = -head_delta;
            dist_delta = t.travelled_cm - track.prev_distance;
            dist_mag = dist_delta[31] ? -dist_delta : dist_delta;
            speed_mag = (t.speed >= track.prev_speed) ? t.speed - track.prev_speed
                                                      : track.prev_speed - t.speed;
            if (head_delta > int'(settings.heading_threshold))
                why = CAUSE_HEADING;
            else if (dist_mag > {16'd0, settings.distance_threshold})
                why = CAUSE_DISTANCE;
            else if (speed_mag > settings.speed_threshold)
                why = CAUSE_SPEED;
            else if (elapsed >= {16'd0, track.gen_interval})
                why = CAUSE_ELAPSED;
        end

        if (why != CAUSE_NONE && t.tx_ok)
        begin
            r.generate_res = 1'b1;
            if (why == CAUSE_HEADING || why == CAUSE_DISTANCE || why == CAUSE_SPEED)
            begin
                track.repeat_count = 3'd1;
                track.dynamic_active = 1'b1;
                clamped = elapsed;
                if (clamped < {16'd0, settings.interval_min_ms})
                    clamped = {16'd0, settings.interval_min_ms};
                if (clamped > {16'd0, settings.interval_max_ms})
                    clamped = {16'd0, settings.interval_max_ms};
                track.gen_interval = clamped[15:0];
            end
            else if (why == CAUSE_ELAPSED && track.dynamic_active)
            begin
                track.repeat_count = track.repeat_count + 3'd1;
                if (track.repeat_count >= settings.repeat_limit)
                begin
                    track.repeat_count = 3'd0;
                    track.dynamic_active = 1'b0;
                    track.gen_interval = settings.interval_max_ms;
                end
            end
            if (t.low_freq_avail && (!track.low_freq_sent ||
                t.now_ms - track.last_low_freq_time >= CONTAINER_GAP_MS))
            begin
                r.with_low_freq = 1'b1;
                track.last_low_freq_time = t.now_ms;
                track.low_freq_sent = 1'b1;
            end
            if (t.special_avail && (!track.special_sent ||
                t.now_ms - track.last_special_time >= CONTAINER_GAP_MS))
            begin
                r.with_special = 1'b1;
                track.last_special_time = t.now_ms;
                track.special_sent = 1'b1;
            end
            track.started = 1'b1;
            track.last_gen_time = t.now_ms;
            track.prev_heading = t.heading;
            track.prev_distance = t.travelled_cm;
            track.prev_speed = t.speed;
        end
        else
            why = CAUSE_NONE;

        r.cause = why;
        r.current_interval_ms = settings.vehicle_mode ? track.gen_interval
                                                      : settings.roadside_period_ms;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            settings = '{vehicle_mode:       1'b1,
                         roadside_period_ms: RST_ROADSIDE_PERIOD,
                         interval_min_ms:    RST_INTERVAL_MIN,
                         interval_max_ms:    RST_INTERVAL_MAX,
                         heading_threshold:  RST_HEADING_THR,
                         distance_threshold: RST_DISTANCE_THR,
                         speed_threshold:    RST_SPEED_THR,
                         repeat_limit:       RST_REPEAT_LIMIT};
            track = '0;
            track.gen_interval = RST_INTERVAL_MAX;
            expected_decisions.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_decisions.size() == 0)
                    report_mismatch("arrived with nothing expected", 0, 0);
                else
                begin
                    want = expected_decisions.pop_front();
                    compare_cnt++;
                    if (generate_res !== want.generate_res)
                        report_mismatch("generate_res", want.generate_res, generate_res);
                    if (cause !== want.cause)
                        report_mismatch("cause", want.cause, cause);
                    if (with_low_freq !== want.with_low_freq)
                        report_mismatch("with_low_freq", want.with_low_freq, with_low_freq);
                    if (with_special !== want.with_special)
                        report_mismatch("with_special", want.with_special, with_special);
                    if (current_interval_ms !== want.current_interval_ms)
                        report_mismatch("current_interval_ms", want.current_interval_ms,
                                        current_interval_ms);
                end
            end
            if (in_valid && !in_stall)
                expected_decisions.push_back(decide_tick(item_t'{now_ms, heading,
                    travelled_cm, speed, tx_ok, low_freq_avail, special_avail}));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VEHICLE_MODE:    settings.vehicle_mode = cfg_data[0];
                    REG_ROADSIDE_PERIOD: settings.roadside_period_ms = cfg_data;
                    REG_INTERVAL_MIN:    settings.interval_min_ms = cfg_data;
                    REG_INTERVAL_MAX:    settings.interval_max_ms = cfg_data;
                    REG_HEADING_THR:     settings.heading_threshold = cfg_data[10:0];
                    REG_DISTANCE_THR:    settings.distance_threshold = cfg_data;
                    REG_SPEED_THR:       settings.speed_threshold = cfg_data[13:0];
                    REG_REPEAT_LIMIT:    settings.repeat_limit = cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        mismatches <= mismatch_cnt;
        outstanding <= expected_decisions.size();
        compared <= compare_cnt;
    end

endmodule

>>> dv/cam_generation_trigger_core_tb.sv
// cam_generation_trigger_core_tb: drives directed and random check ticks and register
// settings into cam_generation_trigger_core with random gaps and output stalls.
// Depends on cgt_pkg, the core RTL and cam_generation_trigger_checker.
`timescale 1ns / 100ps

module cam_generation_trigger_core_tb;
    import cgt_pkg::*;

    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 72;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [31:0]            now_ms;
    logic [11:0]            heading;
    logic [31:0]            travelled_cm;
    logic [13:0]            speed;
    logic                   tx_ok;
    logic                   low_freq_avail;
    logic                   special_avail;
    logic                   out_valid;
    logic                   out_stall;
    logic                   generate_res;
    logic [CAUSE_W-1:0]     cause;
    logic                   with_low_freq;
    logic                   with_special;
    logic [15:0]            current_interval_ms;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int compared;
    int ticks_sent = 0;
    int quiet_cycles = 0;

    cam_generation_trigger_core uut (.*);
    cam_generation_trigger_checker trigger_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tick(input item_t t, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        now_ms         <= t.now_ms;
        heading        <= t.heading;
        travelled_cm   <= t.travelled_cm;
        speed          <= t.speed;
        tx_ok          <= t.tx_ok;
        low_freq_avail <= t.low_freq_avail;
        special_avail  <= t.special_avail;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input int phase);
        logic [15:0] mode, period, imin, imax, hthr, dthr, sthr, rlim;
        case (phase)
            // zero thresholds, zero interval, repeat limit 0
            0: {mode, period, imin, imax, hthr, dthr, sthr, rlim} =
                   {16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            1: {mode, period, imin, imax, hthr, dthr, sthr, rlim} = {8{16'hFFFF}};
            2: {mode, period, imin, imax, hthr, dthr, sthr, rlim} =
                   {16'd0, 16'd1, 16'd100, 16'd1000, 16'd40, 16'd400, 16'd50, 16'd3};
            3: {mode, period, imin, imax, hthr, dthr, sthr, rlim} =
                   {16'hFFFE, 16'hFFFF, 16'd20, 16'd600, 16'd60, 16'd500, 16'd80, 16'd2};
            // min above max
            4: {mode, period, imin, imax, hthr, dthr, sthr, rlim} =
                   {16'd1, 16'd700, 16'd800, 16'd200, 16'd30, 16'd300, 16'd40, 16'd2};
            5: {mode, period, imin, imax, hthr, dthr, sthr, rlim} =
                   {16'd1, 16'd500, 16'd50, 16'd300, 16'd20, 16'd200, 16'd30, 16'd1};
            default:
            begin
                mode   = 16'($urandom_range(0, 1));
                period = 16'($urandom_range(1, 3000));
                imin   = 16'($urandom_range(1, 500));
                imax   = 16'($urandom_range(1, 2000));
                hthr   = 16'($urandom_range(0, 200));
                dthr   = 16'($urandom_range(0, 1500));
                sthr   = 16'($urandom_range(0, 200));
                rlim   = 16'($urandom_range(0, 7));
            end
        endcase
        write_reg(REG_VEHICLE_MODE, mode);
        write_reg(REG_ROADSIDE_PERIOD, period);
        write_reg(REG_INTERVAL_MIN, imin);
        write_reg(REG_INTERVAL_MAX, imax);
        write_reg(REG_HEADING_THR, hthr);
        write_reg(REG_DISTANCE_THR, dthr);
        write_reg(REG_SPEED_THR, sthr);
        write_reg(REG_REPEAT_LIMIT, rlim);
        cfg_valid <= 1'b0;
    endtask

    // receiver stalls: short and long bursts, with long stall-free stretches
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            repeat (($urandom_range(0, 9) == 0) ? 150 : pick_gap() + 1) @(posedge clk);
            out_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("cam_generation_trigger_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        item_t       tick;
        logic [31:0] sim_now;
        logic [31:0] sim_dist;
        logic [11:0] sim_hdg;
        logic [13:0] sim_spd;
        int          roll;
        int          sp;
        int          gap;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        now_ms         <= '0;
        heading        <= '0;
        travelled_cm   <= '0;
        speed          <= '0;
        tx_ok          <= 1'b0;
        low_freq_avail <= 1'b0;
        special_avail  <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_VEHICLE_MODE;
        cfg_data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under reset defaults
        send_tick('{32'd0, 12'd0, 32'd0, 14'd0, 1'b0, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd5, 12'd3590, 32'd0, 14'd0, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd50, 12'd20, 32'd0, 14'd0, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd100, 12'd3560, 32'd0, 14'd0, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd150, 12'd3549, 32'd0, 14'd0, 1'b1, 1'b1, 1'b0}, pick_gap());
        send_tick('{32'd200, 12'd3549, 32'd401, 14'd0, 1'b1, 1'b0, 1'b1}, pick_gap());
        send_tick('{32'd260, 12'd3549, 32'hFFFF_FFFF, 14'd0, 1'b1, 1'b0, 1'b0}, pick_gap());
        send_tick('{32'd300, 12'd3549, 32'h0000_0080, 14'd50, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd310, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd410, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd510, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd1509, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd1510, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b0, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'd1511, 12'd3549, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b0, 1'b1}, pick_gap());
        send_tick('{32'd1520, 12'd4095, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b0}, pick_gap());
        send_tick('{32'd1530, 12'd0, 32'hFFFF_FFFF, 14'd51, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'hFFFF_FFF0, 12'd3599, 32'd0, 14'h3FFF, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'h0000_0010, 12'd3599, 32'd0, 14'h3FFF, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'h0000_0400, 12'd3599, 32'd0, 14'h3FFF, 1'b1, 1'b1, 1'b1}, pick_gap());
        send_tick('{32'h0000_0500, 12'd3599, 32'd0, 14'd0, 1'b1, 1'b0, 1'b0}, pick_gap());
        send_tick('{32'h0000_0510, 12'd1799, 32'd0, 14'd0, 1'b1, 1'b1, 1'b1}, pick_gap());
        wait_idle();

        sim_now  = 32'hFFFE_0000;
        sim_dist = 32'hFFFF_F000;
        sim_hdg  = 12'd1799;
        sim_spd  = 14'd0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_setting(phase);
            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 88)
                begin
                    if (roll < 60)
                        sim_now += $urandom_range(0, 150);
                    else if (roll < 80)
                        sim_now += $urandom_range(100, 1200);
                    else
                        sim_now += $urandom_range(0, 70000);
                    if ($urandom_range(0, 19) == 0)
                        sim_hdg = 12'((sim_hdg + $urandom_range(1700, 1900)) % 3600);
                    else
                        sim_hdg = 12'((sim_hdg + 3540 + $urandom_range(0, 120)) % 3600);
                    if ($urandom_range(0, 9) == 0)
                        sim_dist -= $urandom_range(0, 900);
                    else
                        sim_dist += $urandom_range(0, 600);
                    sp = int'(sim_spd) + int'($urandom_range(0, 120)) - 60;
                    sim_spd = (sp < 0) ? 14'd0 : (sp > 16383) ? 14'h3FFF : 14'(sp);
                    tick = '{sim_now, sim_hdg, sim_dist, sim_spd,
                             ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))};
                end
                else
                    tick = '{$urandom, 12'($urandom), $urandom, 14'($urandom),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))};
                gap = (k >= 20 && k < 36) ? 0 : pick_gap();
                send_tick(tick, gap);
            end
            wait_idle();
        end

        $display("sent %0d ticks over reset defaults and %0d register settings",
                 ticks_sent, PHASES);
        $display("compared %0d decisions, %0d field mismatches", compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("cam_generation_trigger_core: match");
        else
            $display("cam_generation_trigger_core: mismatch");
        $finish;
    end

endmodule
